FILE: rtl/core/fpsa_pkg.sv
// shared types and constants of the free page stack allocator
`default_nettype none

package fpsa_pkg;

  localparam int unsigned ADDR_W = 24;
  localparam int unsigned REG_W  = 25;
  localparam int unsigned CNT_W  = 13;
  localparam int unsigned IDX_SEL_W = 1;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [REG_W-1:0] LOW_BOUND_RST   = '0;
  localparam logic [REG_W-1:0] UPPER_LIMIT_RST = REG_W'(1) << ADDR_W;

  // register indexes on the config port
  localparam logic [IDX_SEL_W-1:0] REG_LOW_BOUND   = 1'b0;
  localparam logic [IDX_SEL_W-1:0] REG_UPPER_LIMIT = 1'b1;

  // request kinds
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_MISALIGNED = 3'd1,
    ST_BELOW      = 3'd2,
    ST_BEYOND     = 3'd3,
    ST_EMPTY      = 3'd4
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_POP  = 1'b1
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic accept;  // request beat taken this cycle
    logic pop;     // load head from the link read data
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pop_ok;  // current request is an allocate that will pop
  } sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/fpsa_ctrl.sv
// controller of the free page stack allocator: handshake and pop sequencing
`default_nettype none

module fpsa_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire fpsa_pkg::sts_t sts_i,
  output fpsa_pkg::cmd_t     cmd_o
);
  import fpsa_pkg::*;

  state_e state_q, state_d;
  logic   out_vld_q, out_vld_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    out_vld_d  = out_vld_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    if (out_vld_q && out_ready_i) begin
      out_vld_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        in_ready_o   = !out_vld_q || out_ready_i;
        cmd_o.accept = in_valid_i && in_ready_o;
        if (cmd_o.accept) begin
          out_vld_d = 1'b1;
          if (sts_i.pop_ok) begin
            state_d = S_POP;
          end
        end
      end
      S_POP: begin
        // link read data is registered now
        cmd_o.pop = 1'b1;
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_vld_q;

endmodule

`default_nettype wire

FILE: rtl/core/fpsa_dp.sv
// datapath of the free page stack allocator: head, link ram, counters, result
`default_nettype none

module fpsa_dp #(
  parameter int unsigned PAGE_BITS = 12,
  parameter int unsigned NUM_PAGES = 4096
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [fpsa_pkg::IDX_SEL_W-1:0] cfg_idx_i,
  input  wire logic [fpsa_pkg::REG_W-1:0]     cfg_data_i,
  input  wire logic                           op_i,
  input  wire logic [fpsa_pkg::ADDR_W-1:0]    page_addr_i,
  input  wire fpsa_pkg::cmd_t                 cmd_i,
  output fpsa_pkg::sts_t                      sts_o,
  output fpsa_pkg::status_e                   status_o,
  output logic [fpsa_pkg::ADDR_W-1:0]         granted_addr_o,
  output logic [fpsa_pkg::CNT_W-1:0]          free_pages_o,
  output logic [fpsa_pkg::CNT_W-1:0]          used_pages_o
);
  import fpsa_pkg::*;

  localparam int unsigned IDX_W  = $clog2(NUM_PAGES);
  localparam int unsigned WIDE_W = 48;
  localparam logic [REG_W:0]    PAGE_BYTES = (REG_W+1)'(1) << PAGE_BITS;
  localparam logic [ADDR_W-1:0] PAGE_MASK  = ADDR_W'(PAGE_BYTES - 1'b1);

  // config registers
  logic [REG_W-1:0] low_q, upper_q;

  // list head and link memory (valid bit on top)
  logic             head_vld_q;
  logic [IDX_W-1:0] head_idx_q;
  logic [IDX_W:0]   link_mem [NUM_PAGES];
  logic [IDX_W:0]   rd_q;

  logic [CNT_W-1:0] free_q, free_d;
  logic [CNT_W-1:0] used_q, used_d;

  logic [WIDE_W-1:0] fidx_wide, haddr_wide;
  logic [IDX_W-1:0]  widx;
  logic [ADDR_W-1:0] head_addr;
  status_e           free_st, alloc_st, req_st;
  logic              free_ok, alloc_ok;

  function automatic status_e chk(input logic [ADDR_W-1:0] a,
                                  input logic [REG_W-1:0] lo,
                                  input logic [REG_W-1:0] hi);
    logic [REG_W:0] end_addr;
    end_addr = (REG_W+1)'(a) + PAGE_BYTES;
    if (|(a & PAGE_MASK)) begin
      return ST_MISALIGNED;
    end else if (REG_W'(a) < lo) begin
      return ST_BELOW;
    end else if (end_addr > (REG_W+1)'(hi)) begin
      return ST_BEYOND;
    end
    return ST_OK;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q   <= LOW_BOUND_RST;
      upper_q <= UPPER_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LOW_BOUND:   low_q   <= cfg_data_i;
        REG_UPPER_LIMIT: upper_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // free path
  always_comb begin
    fidx_wide = WIDE_W'(page_addr_i) >> PAGE_BITS;
    widx      = fidx_wide[IDX_W-1:0];
    free_st   = chk(page_addr_i, low_q, upper_q);
    if (free_st == ST_OK && fidx_wide >= WIDE_W'(NUM_PAGES)) begin
      free_st = ST_BEYOND;
    end
    free_ok = (op_i == OP_FREE) && (free_st == ST_OK);
  end

  // allocate path, head page address
  always_comb begin
    haddr_wide = WIDE_W'(head_idx_q) << PAGE_BITS;
    head_addr  = haddr_wide[ADDR_W-1:0];
    alloc_st   = head_vld_q ? chk(head_addr, low_q, upper_q) : ST_EMPTY;
    alloc_ok   = (op_i == OP_ALLOC) && (alloc_st == ST_OK);
    req_st     = (op_i == OP_FREE) ? free_st : alloc_st;
  end

  assign sts_o.pop_ok = alloc_ok;

  // saturating counters
  always_comb begin
    free_d = free_q;
    used_d = used_q;
    if (free_ok) begin
      if (free_q != CNT_MAX) free_d = free_q + 1'b1;
      if (used_q != '0)      used_d = used_q - 1'b1;
    end else if (alloc_ok) begin
      if (used_q != CNT_MAX) used_d = used_q + 1'b1;
      if (free_q != '0)      free_d = free_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= 1'b0;
      head_idx_q <= '0;
      free_q     <= '0;
      used_q     <= '0;
    end else begin
      if (cmd_i.accept) begin
        free_q <= free_d;
        used_q <= used_d;
        if (free_ok) begin
          head_vld_q <= 1'b1;
          head_idx_q <= widx;
        end
      end else if (cmd_i.pop) begin
        head_vld_q <= rd_q[IDX_W];
        head_idx_q <= rd_q[IDX_W-1:0];
      end
    end
  end

  // link memory: push writes old head, allocate reads link of head
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && free_ok) begin
      link_mem[widx] <= {head_vld_q, head_idx_q};
    end
    if (cmd_i.accept) begin
      rd_q <= link_mem[head_idx_q];
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      status_o       <= req_st;
      granted_addr_o <= alloc_ok ? head_addr : '0;
      free_pages_o   <= free_d;
      used_pages_o   <= used_d;
    end
  end

  a_pop_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> $past(cmd_i.accept) && $past(alloc_ok))
    else $error("pop without a preceding allocate");

  a_push_sets_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.accept && free_ok) |=> head_vld_q && head_idx_q == $past(widx))
    else $error("push did not update head");

  a_no_accept_on_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> !cmd_i.accept ##1 ($stable(free_q) && $stable(used_q)))
    else $error("request taken during pop");

endmodule

`default_nettype wire

FILE: rtl/core/free_page_stack_allocator_core.sv
// top level of the free page stack allocator core
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tuser op, tdata page_addr
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata status, addr, counts
//  cfg       in   cfg_we_i                       cfg_idx_i, cfg_data_i
//
// a free or a refused request leaves the controller idle, an allocate that pops
// moves it to a pop state: the link of the head page is read from the link ram
// with a registered read, and the head is reloaded from it in the pop state
// a new request is taken while the previous result is leaving the output
// register, so frees and refused requests run one per cycle if m_axis keeps up
// reset clears the head valid bit, both counters and the result valid flag;
// the link ram is not cleared, since an entry is always written before use
// a stalled m_axis holds the result register and back-pressures s_axis
`default_nettype none

module free_page_stack_allocator_core #(
  parameter int unsigned PAGE_BITS = 12,
  parameter int unsigned NUM_PAGES = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // config write port
  input  wire logic                           cfg_we_i,
  input  wire logic [fpsa_pkg::IDX_SEL_W-1:0] cfg_idx_i,
  input  wire logic [fpsa_pkg::REG_W-1:0]     cfg_data_i,
  // request beats
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // [23:0] page_addr
  input  wire logic        s_axis_tuser,   // [0] op
  // result beats
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [55:0]      m_axis_tdata    // [2:0] status, [26:3] granted_addr,
                                           // [39:27] free_pages, [52:40] used_pages,
                                           // [55:53] zero
);
  import fpsa_pkg::*;

  cmd_t              cmd;
  sts_t              sts;
  status_e           status;
  logic [ADDR_W-1:0] granted_addr;
  logic [CNT_W-1:0]  free_pages, used_pages;

  fpsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fpsa_dp #(
    .PAGE_BITS (PAGE_BITS),
    .NUM_PAGES (NUM_PAGES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .op_i           (s_axis_tuser),
    .page_addr_i    (s_axis_tdata),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .status_o       (status),
    .granted_addr_o (granted_addr),
    .free_pages_o   (free_pages),
    .used_pages_o   (used_pages)
  );

  // pack the result beat, status in the lowest bits
  assign m_axis_tdata = {3'b000, used_pages, free_pages, granted_addr, status};

endmodule

`default_nettype wire
